/* hdl/srb_pkg.sv */
package srb_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int CMD_W       = 2;
    localparam int CAP_CFG_W   = 7;
    localparam int COUNT_OUT_W = 6;
    localparam int FREE_W      = 7;
    localparam int MEAN_W      = 16;
    localparam int TDATA_OUT_W = 48;
    localparam int CAP_RESET   = 64;
    localparam int CAP_MIN     = 2;
    localparam int DIV_STEPS   = 2;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_QUERY = 2'd2
    } cmd_t;

    typedef enum logic {
        FRONT_IDLE,
        FRONT_EXEC
    } front_state_t;

    typedef enum logic [1:0] {
        BACK_IDLE,
        BACK_DIV,
        BACK_HOLD
    } back_state_t;

endpackage

/* hdl/sample_ring_buffer_with_mean.sv */
// Channel   Dir  Handshake              Payload
// cfg       in   cfg_valid/cfg_ready    cfg_data: capacity
// s_        in   s_tvalid/s_tready      s_tuser: cmd, s_tdata: sample_in
// m_        out  m_tvalid/m_tready      m_tuser: was_empty, m_tdata: result fields
//
// Front end cannot take a new request until the last is done (store read, then
// pointer/sum update), and waits while the queue is full. Back end works a request
// through queue pop, divider steps at 2 quotient bits each and output load, and pops
// no new request until the last result is loaded; the divider sets the sustained rate.
// Reset is synchronous, active low; no clearing pass, store contents are undefined.
// A two-entry queue separates front and back; the output register lets the back
// end finish the next division while a result waits.
module sample_ring_buffer_with_mean #(
    parameter int DEPTH = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [srb_pkg::CAP_CFG_W-1:0]       cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [srb_pkg::SAMPLE_W-1:0]        s_tdata,   // [15:0] sample_in
    input  logic [srb_pkg::CMD_W-1:0]           s_tuser,   // [1:0] cmd
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [15:0] read_data, [21:16] stored_count, [28:22] free_slots, [44:29] mean_value
    output logic [srb_pkg::TDATA_OUT_W-1:0]     m_tdata,
    output logic                                m_tuser    // [0] was_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CAP_W = $clog2(DEPTH + 1);
    localparam int SUM_W = srb_pkg::SAMPLE_W + PTR_W;
    localparam int EW    = SUM_W + CAP_W + srb_pkg::FREE_W + 1 + srb_pkg::SAMPLE_W;

    logic          q_push;
    logic          q_full;
    logic [EW-1:0] q_push_data;
    logic          q_pop;
    logic          q_empty;
    logic [EW-1:0] q_pop_data;

    srb_front #(
        .DEPTH (DEPTH),
        .EW    (EW)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .s_cmd     (s_tuser),
        .s_sample  (s_tdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_push_data)
    );

    srb_queue #(
        .WIDTH (EW)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    srb_back #(
        .DEPTH (DEPTH),
        .EW    (EW)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .q_data  (q_pop_data),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_data  (m_tdata),
        .m_user  (m_tuser)
    );

    a_accept_pushes: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> q_push)
        else $error("accepted request not forwarded to queue");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("queue push while full");

    a_pop_data: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty)
        else $error("queue pop while empty");

    a_push_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |=> !q_empty)
        else $error("queue empty after push");

endmodule

/* hdl/srb_queue.sv */
module srb_queue #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int QD   = srb_pkg::QUEUE_DEPTH;
    localparam int QP_W = (QD > 1) ? $clog2(QD) : 1;
    localparam int QC_W = $clog2(QD + 1);

    logic [WIDTH-1:0] entry_reg [QD];
    logic [QP_W-1:0]  wr_ptr_reg;
    logic [QP_W-1:0]  rd_ptr_reg;
    logic [QC_W-1:0]  fill_reg;
    logic             do_push;
    logic             do_pop;

    assign full     = (fill_reg == QC_W'(QD));
    assign empty    = (fill_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == QP_W'(QD - 1)) ? '0 : wr_ptr_reg + QP_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QP_W'(QD - 1)) ? '0 : rd_ptr_reg + QP_W'(1);
            end
            if (do_push && !do_pop) begin
                fill_reg <= fill_reg + QC_W'(1);
            end else if (do_pop && !do_push) begin
                fill_reg <= fill_reg - QC_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hdl/srb_front.sv */
module srb_front #(
    parameter int DEPTH = 64,
    parameter int EW    = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [srb_pkg::CAP_CFG_W-1:0]    cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [srb_pkg::CMD_W-1:0]        s_cmd,
    input  logic [srb_pkg::SAMPLE_W-1:0]     s_sample,
    input  logic                             q_full,
    output logic                             q_push,
    output logic [EW-1:0]                    q_data
);

    localparam int PTR_W   = $clog2(DEPTH);
    localparam int CAP_W   = $clog2(DEPTH + 1);
    localparam int CW      = (CAP_W > srb_pkg::CAP_CFG_W) ? CAP_W : srb_pkg::CAP_CFG_W;
    localparam int SUM_W   = srb_pkg::SAMPLE_W + PTR_W;
    localparam int CAP_RST = (DEPTH < srb_pkg::CAP_RESET) ? DEPTH : srb_pkg::CAP_RESET;

    srb_pkg::front_state_t state_reg, state_next;

    logic [srb_pkg::SAMPLE_W-1:0] sample_store [DEPTH];

    logic [CAP_W-1:0]             cap_reg;
    logic [PTR_W-1:0]             wp_reg, wp_next;
    logic [PTR_W-1:0]             rp_reg, rp_next;
    logic [CAP_W-1:0]             cnt_reg, cnt_next;
    logic [SUM_W-1:0]             sum_reg, sum_next;
    srb_pkg::cmd_t                cmd_reg;
    logic [srb_pkg::SAMPLE_W-1:0] sample_reg;
    logic [srb_pkg::SAMPLE_W-1:0] rdat_reg;

    logic                         accept;
    logic                         cfg_write;
    logic                         is_full;
    logic                         is_empty;
    logic [PTR_W-1:0]             wp_adv;
    logic [PTR_W-1:0]             rp_adv;
    logic [srb_pkg::SAMPLE_W-1:0] rd_out;
    logic                         empty_out;
    logic [CW-1:0]                free_wide;
    logic [CW-1:0]                cfg_ext;
    logic [CAP_W-1:0]             cap_clamp;

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                                 input logic [CAP_W-1:0] cap);
        logic [CAP_W-1:0] p1;
        p1 = CAP_W'(p) + CAP_W'(1);
        return (p1 >= cap) ? '0 : p1[PTR_W-1:0];
    endfunction

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            srb_pkg::FRONT_IDLE: begin
                if (accept) begin
                    state_next = srb_pkg::FRONT_EXEC;
                end
            end
            srb_pkg::FRONT_EXEC: begin
                state_next = srb_pkg::FRONT_IDLE;
            end
            default: begin
                state_next = srb_pkg::FRONT_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        s_ready   = 1'b0;
        cfg_ready = 1'b0;
        q_push    = 1'b0;
        case (state_reg)
            srb_pkg::FRONT_IDLE: begin
                s_ready   = !q_full;
                cfg_ready = 1'b1;
            end
            srb_pkg::FRONT_EXEC: begin
                q_push = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    assign accept    = s_valid && s_ready;
    assign cfg_write = cfg_valid && cfg_ready;

    assign cfg_ext = CW'(cfg_data);
    always_comb begin
        if (cfg_ext < CW'(srb_pkg::CAP_MIN)) begin
            cap_clamp = CAP_W'(srb_pkg::CAP_MIN);
        end else if (cfg_ext > CW'(DEPTH)) begin
            cap_clamp = CAP_W'(DEPTH);
        end else begin
            cap_clamp = cfg_ext[CAP_W-1:0];
        end
    end

    assign is_full  = (cnt_reg == cap_reg - CAP_W'(1));
    assign is_empty = (cnt_reg == '0);
    assign wp_adv   = advance(wp_reg, cap_reg);
    assign rp_adv   = advance(rp_reg, cap_reg);

    always_comb begin
        wp_next   = wp_reg;
        rp_next   = rp_reg;
        cnt_next  = cnt_reg;
        sum_next  = sum_reg;
        rd_out    = '0;
        empty_out = 1'b0;
        case (cmd_reg)
            srb_pkg::CMD_PUSH: begin
                wp_next  = wp_adv;
                sum_next = sum_reg + SUM_W'(sample_reg)
                         - (is_full ? SUM_W'(rdat_reg) : SUM_W'(0));
                if (is_full) begin
                    rp_next = rp_adv;
                end else begin
                    cnt_next = cnt_reg + CAP_W'(1);
                end
            end
            srb_pkg::CMD_POP: begin
                if (is_empty) begin
                    empty_out = 1'b1;
                end else begin
                    rd_out   = rdat_reg;
                    sum_next = sum_reg - SUM_W'(rdat_reg);
                    rp_next  = rp_adv;
                    cnt_next = cnt_reg - CAP_W'(1);
                end
            end
            default: begin
                rd_out = '0;
            end
        endcase
    end

    assign free_wide = CW'(cap_reg) - CW'(cnt_next);
    assign q_data    = {rd_out, empty_out, free_wide[srb_pkg::FREE_W-1:0], cnt_next, sum_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= srb_pkg::FRONT_IDLE;
            cap_reg   <= CAP_W'(CAP_RST);
            wp_reg    <= '0;
            rp_reg    <= '0;
            cnt_reg   <= '0;
            sum_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_write) begin
                cap_reg <= cap_clamp;
                wp_reg  <= '0;
                rp_reg  <= '0;
                cnt_reg <= '0;
                sum_reg <= '0;
            end else if (state_reg == srb_pkg::FRONT_EXEC) begin
                wp_reg  <= wp_next;
                rp_reg  <= rp_next;
                cnt_reg <= cnt_next;
                sum_reg <= sum_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg    <= srb_pkg::cmd_t'(s_cmd);
            sample_reg <= s_sample;
        end
    end

    // sample store: write on push, oldest entry read on every request
    always_ff @(posedge aclk) begin
        if (accept) begin
            if (s_cmd == srb_pkg::CMD_PUSH) begin
                sample_store[wp_reg] <= s_sample;
            end
            rdat_reg <= sample_store[rp_reg];
        end
    end

endmodule

/* hdl/srb_back.sv */
module srb_back #(
    parameter int DEPTH = 64,
    parameter int EW    = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               q_empty,
    output logic                               q_pop,
    input  logic [EW-1:0]                      q_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [srb_pkg::TDATA_OUT_W-1:0]    m_data,
    output logic                               m_user
);

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CAP_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = srb_pkg::SAMPLE_W + PTR_W;
    localparam int R_W    = CAP_W + 1;
    localparam int CNT_XW = (CAP_W > srb_pkg::COUNT_OUT_W) ? CAP_W : srb_pkg::COUNT_OUT_W;
    localparam int ITERS  = srb_pkg::MEAN_W / srb_pkg::DIV_STEPS;
    localparam int ITER_W = $clog2(ITERS);
    localparam int PAD_W  = srb_pkg::TDATA_OUT_W - 2 * srb_pkg::MEAN_W
                          - srb_pkg::COUNT_OUT_W - srb_pkg::FREE_W;
    localparam int O_CNT  = SUM_W;
    localparam int O_FREE = O_CNT + CAP_W;
    localparam int O_EMP  = O_FREE + srb_pkg::FREE_W;
    localparam int O_RD   = O_EMP + 1;

    srb_pkg::back_state_t state_reg, state_next;

    logic [ITER_W-1:0]              step_reg;
    logic [R_W-1:0]                 rem_reg;
    logic [srb_pkg::MEAN_W-1:0]     qd_reg;
    logic [CAP_W-1:0]               div_reg;
    logic [srb_pkg::SAMPLE_W-1:0]   rd_reg;
    logic                           empty_reg;
    logic [srb_pkg::FREE_W-1:0]     free_reg;
    logic                           m_valid_reg;
    logic [srb_pkg::TDATA_OUT_W-1:0] m_data_reg;
    logic                           m_user_reg;

    logic [SUM_W-1:0]               in_sum;
    logic [R_W-1:0]                 rem_chain [srb_pkg::DIV_STEPS+1];
    logic [R_W-1:0]                 rem_shift [srb_pkg::DIV_STEPS];
    logic [srb_pkg::MEAN_W-1:0]     qd_chain  [srb_pkg::DIV_STEPS+1];
    logic                           load_out;
    logic [srb_pkg::MEAN_W-1:0]     mean;
    logic [CNT_XW-1:0]              cnt_wide;

    assign in_sum = q_data[SUM_W-1:0];

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            srb_pkg::BACK_IDLE: begin
                if (!q_empty) begin
                    state_next = srb_pkg::BACK_DIV;
                end
            end
            srb_pkg::BACK_DIV: begin
                if (step_reg == ITER_W'(ITERS - 1)) begin
                    state_next = srb_pkg::BACK_HOLD;
                end
            end
            srb_pkg::BACK_HOLD: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = srb_pkg::BACK_IDLE;
                end
            end
            default: begin
                state_next = srb_pkg::BACK_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        q_pop    = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            srb_pkg::BACK_IDLE: begin
                q_pop = !q_empty;
            end
            srb_pkg::BACK_HOLD: begin
                load_out = !m_valid_reg || m_ready;
            end
            default: begin
                q_pop = 1'b0;
            end
        endcase
    end

    // restoring divide, DIV_STEPS quotient bits a cycle
    always_comb begin
        rem_chain[0] = rem_reg;
        qd_chain[0]  = qd_reg;
        for (int i = 0; i < srb_pkg::DIV_STEPS; i++) begin
            rem_shift[i] = {rem_chain[i][R_W-2:0], qd_chain[i][srb_pkg::MEAN_W-1]};
            if (rem_shift[i] >= R_W'(div_reg)) begin
                rem_chain[i+1] = rem_shift[i] - R_W'(div_reg);
                qd_chain[i+1]  = {qd_chain[i][srb_pkg::MEAN_W-2:0], 1'b1};
            end else begin
                rem_chain[i+1] = rem_shift[i];
                qd_chain[i+1]  = {qd_chain[i][srb_pkg::MEAN_W-2:0], 1'b0};
            end
        end
    end

    assign mean     = (div_reg == '0) ? '0 : qd_reg;
    assign cnt_wide = CNT_XW'(div_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= srb_pkg::BACK_IDLE;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (q_pop) begin
                step_reg <= '0;
            end else if (state_reg == srb_pkg::BACK_DIV) begin
                step_reg <= step_reg + ITER_W'(1);
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            rem_reg   <= R_W'(in_sum[SUM_W-1:srb_pkg::MEAN_W]);
            qd_reg    <= in_sum[srb_pkg::MEAN_W-1:0];
            div_reg   <= q_data[O_CNT +: CAP_W];
            free_reg  <= q_data[O_FREE +: srb_pkg::FREE_W];
            empty_reg <= q_data[O_EMP];
            rd_reg    <= q_data[O_RD +: srb_pkg::SAMPLE_W];
        end else if (state_reg == srb_pkg::BACK_DIV) begin
            rem_reg <= rem_chain[srb_pkg::DIV_STEPS];
            qd_reg  <= qd_chain[srb_pkg::DIV_STEPS];
        end
        if (load_out) begin
            m_data_reg <= {PAD_W'(0), mean, free_reg,
                           cnt_wide[srb_pkg::COUNT_OUT_W-1:0], rd_reg};
            m_user_reg <= empty_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign m_user  = m_user_reg;

endmodule
